[rtl/tlfb_pkg.sv]
// Shared types, constants and colour tables for the tally LED frame builder.
`default_nettype none

package tlfb_pkg;

  localparam int LED_SLOTS      = 8;
  localparam int LED_IDX_W      = 3;
  localparam int STATE_W        = 3;
  localparam int REQ_W          = 3;
  localparam int BYTE_IDX_W     = 5;
  localparam int TALLY_IDX_W    = 6;
  localparam int CMDQ_DEPTH     = 2;
  localparam int LAMP_COUNT_DEF = 8;

  localparam logic [7:0] BRIGHT_RESET = 8'd255;
  localparam logic [7:0] CAM_RESET    = 8'd1;

  // request type codes
  localparam logic [REQ_W-1:0] REQ_ALL_STATE = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ALL_RGB   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ONE_STATE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ONE_RGB   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BRIGHT    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_TALLY     = 3'd5;

  // LED state codes
  localparam logic [STATE_W-1:0] LED_OFF      = 3'd0;
  localparam logic [STATE_W-1:0] LED_PROGRAM  = 3'd1;
  localparam logic [STATE_W-1:0] LED_PREVIEW  = 3'd2;
  localparam logic [STATE_W-1:0] LED_LIVE     = 3'd3;
  localparam logic [STATE_W-1:0] LED_BATT_LOW = 3'd4;

  typedef enum logic [2:0] {
    OP_SET_ALL,
    OP_ALL_RGB,
    OP_SET_ONE,
    OP_OVR_ONE,
    OP_BRIGHT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [LED_IDX_W-1:0] idx;
    logic [STATE_W-1:0]   st;
    logic [7:0]           r;
    logic [7:0]           g;
    logic [7:0]           b;
    logic [7:0]           bv;
  } cmd_t;

  function automatic logic [7:0] col_r(input logic [STATE_W-1:0] s);
    logic [7:0] v;
    case (s)
      LED_PROGRAM:  v = 8'd255;
      LED_BATT_LOW: v = 8'd255;
      default:      v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] col_g(input logic [STATE_W-1:0] s);
    logic [7:0] v;
    case (s)
      LED_PREVIEW:  v = 8'd255;
      LED_BATT_LOW: v = 8'd255;
      default:      v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] col_b(input logic [STATE_W-1:0] s);
    logic [7:0] v;
    case (s)
      LED_LIVE: v = 8'd255;
      default:  v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/tlfb_front.sv]
// Front end: takes requests, filters no-op requests and turns them into commands.
`default_nettype none

module tlfb_front #(
  parameter int LAMP_COUNT = tlfb_pkg::LAMP_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_push,
  output      logic                            in_full,
  input  wire logic [tlfb_pkg::REQ_W-1:0]      in_req_type,
  input  wire logic [tlfb_pkg::LED_IDX_W-1:0]  in_lamp_sel,
  input  wire logic [tlfb_pkg::STATE_W-1:0]    in_lamp_code,
  input  wire logic [7:0]                      in_red,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_blue,
  input  wire logic [7:0]                      in_brightness_value,
  input  wire logic [7:0]                      in_tally_byte,
  input  wire logic [tlfb_pkg::TALLY_IDX_W-1:0] in_tally_byte_index,
  input  wire logic                            cfg_valid,
  output      logic                            cfg_ready,
  input  wire logic [7:0]                      cfg_camera_number,
  input  wire logic                            q_full,
  output      logic                            q_push,
  output      tlfb_pkg::cmd_t                  q_cmd
);
  import tlfb_pkg::*;

  logic [7:0]         camera_r;
  logic [7:0]         cam_m1;
  logic [7:0]         slot_sh;
  logic [1:0]         slot;
  logic               idx_ok;
  logic               keep;
  logic [STATE_W-1:0] tally_st;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      camera_r <= CAM_RESET;
    end else if (cfg_valid) begin
      camera_r <= (cfg_camera_number == 8'd0) ? 8'd1 : cfg_camera_number;
    end
  end

  always_comb begin
    cam_m1  = camera_r - 8'd1;
    slot_sh = in_tally_byte >> {cam_m1[1:0], 1'b0};
    slot    = slot_sh[1:0];
    case (slot)
      2'd1, 2'd3: tally_st = LED_PROGRAM;
      2'd2:       tally_st = LED_PREVIEW;
      default:    tally_st = LED_OFF;
    endcase
    idx_ok = {1'b0, in_lamp_sel} < (LED_IDX_W+1)'(LAMP_COUNT);

    q_cmd.op  = OP_SET_ALL;
    q_cmd.idx = in_lamp_sel;
    q_cmd.st  = in_lamp_code;
    q_cmd.r   = in_red;
    q_cmd.g   = in_green;
    q_cmd.b   = in_blue;
    q_cmd.bv  = in_brightness_value;
    keep      = 1'b0;
    case (in_req_type)
      REQ_ALL_STATE: keep = 1'b1;
      REQ_ALL_RGB: begin
        q_cmd.op = OP_ALL_RGB;
        keep     = 1'b1;
      end
      REQ_ONE_STATE: begin
        q_cmd.op = OP_SET_ONE;
        keep     = idx_ok;
      end
      REQ_ONE_RGB: begin
        q_cmd.op = OP_OVR_ONE;
        keep     = idx_ok;
      end
      REQ_BRIGHT: begin
        q_cmd.op = OP_BRIGHT;
        keep     = 1'b1;
      end
      REQ_TALLY: begin
        // only the byte that carries this camera's slot acts
        q_cmd.st = tally_st;
        keep     = (in_tally_byte_index == cam_m1[7:2]);
      end
      default: keep = 1'b0;
    endcase
    q_push = in_push && !q_full && keep;
  end

endmodule

`default_nettype wire

[rtl/tlfb_cmd_queue.sv]
// Short command queue between the front end and the frame engine.
`default_nettype none

module tlfb_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tlfb_pkg::cmd_t wr_cmd,
  output      logic           full,
  input  wire logic           pop,
  output      logic           empty,
  output      tlfb_pkg::cmd_t rd_cmd
);
  import tlfb_pkg::*;

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             slots_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CNT_W'(CMDQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slots_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_W'(CMDQ_DEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_W'(CMDQ_DEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wptr_r] <= wr_cmd;
    end
  end

endmodule

`default_nettype wire

[rtl/tlfb_back.sv]
// Frame engine: applies commands to the LED state and streams scaled GRB bytes.
`default_nettype none

module tlfb_back #(
  parameter int LAMP_COUNT = tlfb_pkg::LAMP_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            q_empty,
  input  wire tlfb_pkg::cmd_t                  q_cmd,
  output      logic                            q_pop,
  output      logic                            out_empty,
  input  wire logic                            out_pop,
  output      logic [7:0]                      out_frame_byte,
  output      logic [tlfb_pkg::BYTE_IDX_W-1:0] out_frame_byte_index,
  output      logic                            out_frame_last
);
  import tlfb_pkg::*;

  localparam int FRAME_BYTES = LAMP_COUNT * 3;

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state_r;
  logic [STATE_W-1:0]    states_r [LED_SLOTS];
  logic [7:0]            bright_r;
  logic                  all_rgb_r;
  logic                  ovr_en_r;
  logic [LED_IDX_W-1:0]  ovr_idx_r;
  logic [7:0]            r_r, g_r, b_r;
  logic [LED_IDX_W-1:0]  led_cnt_r;
  logic [1:0]            ch_cnt_r;
  logic [BYTE_IDX_W-1:0] byte_cnt_r;
  logic                  out_valid_r;
  logic [7:0]            out_byte_r;
  logic [BYTE_IDX_W-1:0] out_idx_r;
  logic                  out_last_r;

  logic                  gen;
  logic                  start;
  logic [7:0]            bv_eff;
  logic                  use_rgb;
  logic [STATE_W-1:0]    cur_st;
  logic [7:0]            cr, cg, cb, chan;
  logic [15:0]           prod;
  logic [16:0]           qsum;
  logic                  is_last;

  always_comb begin
    q_pop   = (state_r == ST_IDLE) && !q_empty;
    bv_eff  = (q_cmd.bv == 8'd0) ? 8'd1 : q_cmd.bv;
    // unchanged brightness produces no frame
    start   = q_pop && !((q_cmd.op == OP_BRIGHT) && (bv_eff == bright_r));
    gen     = (state_r == ST_RUN) && (!out_valid_r || out_pop);
    is_last = (byte_cnt_r == BYTE_IDX_W'(FRAME_BYTES - 1));

    use_rgb = all_rgb_r || (ovr_en_r && (led_cnt_r == ovr_idx_r));
    cur_st  = states_r[led_cnt_r];
    cr      = use_rgb ? r_r : col_r(cur_st);
    cg      = use_rgb ? g_r : col_g(cur_st);
    cb      = use_rgb ? b_r : col_b(cur_st);
    case (ch_cnt_r)
      2'd0:    chan = cg;
      2'd1:    chan = cr;
      default: chan = cb;
    endcase
    prod = 16'(chan) * 16'(bright_r);
    // exact x/255 for x a product of two 8-bit values
    qsum = 17'(prod) + 17'(prod[15:8]) + 17'd1;
  end

  assign out_empty            = !out_valid_r;
  assign out_frame_byte       = out_byte_r;
  assign out_frame_byte_index = out_idx_r;
  assign out_frame_last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      bright_r    <= BRIGHT_RESET;
      for (int i = 0; i < LED_SLOTS; i++) begin
        states_r[i] <= LED_OFF;
      end
    end else begin
      if (gen) begin
        out_valid_r <= 1'b1;
        out_byte_r  <= qsum[15:8];
        out_idx_r   <= byte_cnt_r;
        out_last_r  <= is_last;
        byte_cnt_r  <= byte_cnt_r + 1'b1;
        if (is_last) begin
          state_r <= ST_IDLE;
        end
        if (ch_cnt_r == 2'd2) begin
          ch_cnt_r  <= 2'd0;
          led_cnt_r <= led_cnt_r + 1'b1;
        end else begin
          ch_cnt_r <= ch_cnt_r + 1'b1;
        end
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        all_rgb_r <= (q_cmd.op == OP_ALL_RGB);
        ovr_en_r  <= (q_cmd.op == OP_OVR_ONE);
        ovr_idx_r <= q_cmd.idx;
        r_r       <= q_cmd.r;
        g_r       <= q_cmd.g;
        b_r       <= q_cmd.b;
        case (q_cmd.op)
          OP_SET_ALL: begin
            for (int i = 0; i < LED_SLOTS; i++) begin
              states_r[i] <= q_cmd.st;
            end
          end
          OP_SET_ONE: states_r[q_cmd.idx] <= q_cmd.st;
          OP_BRIGHT:  bright_r <= bv_eff;
          default: ;
        endcase
      end
      if (start) begin
        state_r    <= ST_RUN;
        led_cnt_r  <= '0;
        ch_cnt_r   <= 2'd0;
        byte_cnt_r <= '0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tally_led_frame_builder.sv]
// Top level of the tally LED frame builder: front end, command queue, frame engine.
//
//  channel | direction | handshake              | payload
//  in_*    | request   | push / full            | req_type, lamp_sel, lamp_code, rgb,
//          |           |                        | brightness_value, tally byte and index
//  out_*   | result    | empty / pop            | frame_byte, frame_byte_index, frame_last
//  cfg_*   | write     | cfg_valid / cfg_ready  | camera_number
//
// A request that makes a frame streams LAMP_COUNT*3 bytes from the frame engine (one GRB
// byte per cycle while the result consumer keeps popping) after the command is loaded.
// Requests that make no frame are dropped by the front end on acceptance, except an
// unchanged brightness, which takes one queue slot and is then popped by the engine.
// Reset is synchronous: LED states off, brightness 255, camera number 1, queues empty.
// A stalled result consumer holds the engine; the two-entry command queue keeps taking
// requests until it fills.
`default_nettype none

module tally_led_frame_builder #(
  parameter int LAMP_COUNT = tlfb_pkg::LAMP_COUNT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_push,
  output      logic                             in_full,
  input  wire logic [tlfb_pkg::REQ_W-1:0]       in_req_type,
  input  wire logic [tlfb_pkg::LED_IDX_W-1:0]   in_lamp_sel,
  input  wire logic [tlfb_pkg::STATE_W-1:0]     in_lamp_code,
  input  wire logic [7:0]                       in_red,
  input  wire logic [7:0]                       in_green,
  input  wire logic [7:0]                       in_blue,
  input  wire logic [7:0]                       in_brightness_value,
  input  wire logic [7:0]                       in_tally_byte,
  input  wire logic [tlfb_pkg::TALLY_IDX_W-1:0] in_tally_byte_index,
  output      logic                             out_empty,
  input  wire logic                             out_pop,
  output      logic [7:0]                       out_frame_byte,
  output      logic [tlfb_pkg::BYTE_IDX_W-1:0]  out_frame_byte_index,
  output      logic                             out_frame_last,
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [7:0]                       cfg_camera_number
);
  import tlfb_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  tlfb_front #(.LAMP_COUNT(LAMP_COUNT)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_req_type         (in_req_type),
    .in_lamp_sel         (in_lamp_sel),
    .in_lamp_code        (in_lamp_code),
    .in_red              (in_red),
    .in_green            (in_green),
    .in_blue             (in_blue),
    .in_brightness_value (in_brightness_value),
    .in_tally_byte       (in_tally_byte),
    .in_tally_byte_index (in_tally_byte_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_camera_number   (cfg_camera_number),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_cmd               (wr_cmd)
  );

  tlfb_cmd_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_cmd (rd_cmd)
  );

  tlfb_back #(.LAMP_COUNT(LAMP_COUNT)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_cmd                (rd_cmd),
    .q_pop                (q_pop),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_frame_byte       (out_frame_byte),
    .out_frame_byte_index (out_frame_byte_index),
    .out_frame_last       (out_frame_last)
  );

endmodule

`default_nettype wire

[rtl/tlfb_checker.sv]
// Port-level checks for the tally LED frame builder, bound to the top level.
`default_nettype none

module tlfb_checker #(
  parameter int LAMP_COUNT = tlfb_pkg::LAMP_COUNT_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_empty,
  input wire logic                            out_pop,
  input wire logic [7:0]                      out_frame_byte,
  input wire logic [tlfb_pkg::BYTE_IDX_W-1:0] out_frame_byte_index,
  input wire logic                            out_frame_last
);
  import tlfb_pkg::*;

  localparam logic [BYTE_IDX_W-1:0] LAST_IDX = BYTE_IDX_W'(LAMP_COUNT * 3 - 1);

  // nothing is shown right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // frame_last marks exactly the final byte position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_frame_last == (out_frame_byte_index == LAST_IDX)))
    else $error("frame_last does not match byte index");

  // bytes of one frame follow without gaps, index counting up
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_frame_last) |=>
      (!out_empty && (out_frame_byte_index == $past(out_frame_byte_index) + 1'b1)))
    else $error("frame byte sequence broken");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_frame_byte) && $stable(out_frame_byte_index)))
    else $error("waiting result changed");

endmodule

bind tally_led_frame_builder tlfb_checker #(.LAMP_COUNT(LAMP_COUNT)) u_tlfb_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_empty            (out_empty),
  .out_pop              (out_pop),
  .out_frame_byte       (out_frame_byte),
  .out_frame_byte_index (out_frame_byte_index),
  .out_frame_last       (out_frame_last)
);

`default_nettype wire

[verif/tally_led_frame_builder_test.sv]
// Self-checking testbench for the tally LED frame builder: directed table, then random requests.
module tally_led_frame_builder_test;
  import tlfb_pkg::*;

  localparam int NLEDS         = 8;
  localparam int FRAME_LEN     = NLEDS * 3;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_FRAMES  = 48;

  // request and state codes the package leaves unnamed
  localparam logic [REQ_W-1:0]   REQ_SPARE6 = 3'd6;
  localparam logic [REQ_W-1:0]   REQ_SPARE7 = 3'd7;
  localparam logic [STATE_W-1:0] LED_SPARE7 = 3'd7;

  // camera slot codes inside a tally byte
  localparam logic [1:0] SLOT_PGM     = 2'd1;
  localparam logic [1:0] SLOT_PVW     = 2'd2;
  localparam logic [1:0] SLOT_PGM_ALT = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]       req;
    logic [LED_IDX_W-1:0]   idx;
    logic [STATE_W-1:0]     st;
    logic [7:0]             r;
    logic [7:0]             g;
    logic [7:0]             b;
    logic [7:0]             bv;
    logic [7:0]             tb;
    logic [TALLY_IDX_W-1:0] ti;
  } led_req_t;

  typedef enum {BY_MODEL, NO_FRAME, FLAT_FRAME} check_kind_t;

  typedef struct {
    led_req_t    rq;
    check_kind_t chk;
    logic [7:0]  fg;
    logic [7:0]  fr;
    logic [7:0]  fb;
  } dir_row_t;

  typedef struct {
    logic [7:0]            data;
    logic [BYTE_IDX_W-1:0] pos;
    logic                  last;
  } led_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_push;
  logic                   in_full;
  logic [REQ_W-1:0]       in_req_type;
  logic [LED_IDX_W-1:0]   in_lamp_sel;
  logic [STATE_W-1:0]     in_lamp_code;
  logic [7:0]             in_red;
  logic [7:0]             in_green;
  logic [7:0]             in_blue;
  logic [7:0]             in_brightness_value;
  logic [7:0]             in_tally_byte;
  logic [TALLY_IDX_W-1:0] in_tally_byte_index;
  logic                   out_empty;
  logic                   out_pop = 1'b0;
  logic [7:0]             out_frame_byte;
  logic [BYTE_IDX_W-1:0]  out_frame_byte_index;
  logic                   out_frame_last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [7:0]             cfg_camera_number;

  // predictor state
  logic [STATE_W-1:0] led_st [NLEDS];
  logic [7:0]         bright;
  logic [7:0]         cam;

  led_byte_t frame_scratch[$];
  led_byte_t frame_bytes_due[$];
  dir_row_t  directed[$];

  int errors      = 0;
  int pop_hold    = 0;
  bit pop_steady  = 1'b0;
  bit push_steady = 1'b0;

  tally_led_frame_builder #(.LAMP_COUNT(NLEDS)) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_req_type          (in_req_type),
    .in_lamp_sel          (in_lamp_sel),
    .in_lamp_code         (in_lamp_code),
    .in_red               (in_red),
    .in_green             (in_green),
    .in_blue              (in_blue),
    .in_brightness_value  (in_brightness_value),
    .in_tally_byte        (in_tally_byte),
    .in_tally_byte_index  (in_tally_byte_index),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_frame_byte       (out_frame_byte),
    .out_frame_byte_index (out_frame_byte_index),
    .out_frame_last       (out_frame_last),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_camera_number    (cfg_camera_number)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("tally_led_frame_builder regression: fail");
    $finish;
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] dim(input logic [7:0] v);
    logic [15:0] p;
    p = {8'd0, v} * {8'd0, bright};
    return 8'(p / 16'd255);
  endfunction

  // {r, g, b} shown for a stored state
  function automatic logic [23:0] state_colour(input logic [STATE_W-1:0] s);
    case (s)
      LED_PROGRAM:  return 24'hFF0000;
      LED_PREVIEW:  return 24'h00FF00;
      LED_LIVE:     return 24'h0000FF;
      LED_BATT_LOW: return 24'hFFFF00;
      default:      return 24'h000000;
    endcase
  endfunction

  function automatic void build_frame(input int ovr, input bit all_rgb,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [23:0] rgb;
    logic [7:0]  grb [3];
    led_byte_t   lb;
    int          p;
    for (int i = 0; i < NLEDS; i++) begin
      rgb = (all_rgb || i == ovr) ? {r, g, b} : state_colour(led_st[i]);
      grb[0] = rgb[15:8];
      grb[1] = rgb[23:16];
      grb[2] = rgb[7:0];
      for (int k = 0; k < 3; k++) begin
        p = i * 3 + k;
        lb.data = dim(grb[k]);
        lb.pos  = BYTE_IDX_W'(p);
        lb.last = (p == FRAME_LEN - 1);
        frame_scratch.push_back(lb);
      end
    end
  endfunction

  function automatic void set_all_states(input logic [STATE_W-1:0] s);
    for (int i = 0; i < NLEDS; i++) led_st[i] = s;
    build_frame(NLEDS, 1'b0, 8'd0, 8'd0, 8'd0);
  endfunction

  // updates the LED and brightness state; the frame it causes lands in frame_scratch
  function automatic void apply_request(input led_req_t rq);
    logic [7:0] nb;
    logic [7:0] c;
    logic [1:0] slot;
    int         sh;
    frame_scratch.delete();
    case (rq.req)
      REQ_ALL_STATE: set_all_states(rq.st);
      REQ_ALL_RGB:   build_frame(NLEDS, 1'b1, rq.r, rq.g, rq.b);
      REQ_ONE_STATE: begin
        if (int'(rq.idx) < NLEDS) begin
          led_st[rq.idx] = rq.st;
          build_frame(NLEDS, 1'b0, 8'd0, 8'd0, 8'd0);
        end
      end
      REQ_ONE_RGB: begin
        if (int'(rq.idx) < NLEDS) build_frame(int'(rq.idx), 1'b0, rq.r, rq.g, rq.b);
      end
      REQ_BRIGHT: begin
        nb = (rq.bv == 8'd0) ? 8'd1 : rq.bv;
        if (nb != bright) begin
          bright = nb;
          build_frame(NLEDS, 1'b0, 8'd0, 8'd0, 8'd0);
        end
      end
      REQ_TALLY: begin
        c = cam - 8'd1;
        if (rq.ti == c[7:2]) begin
          sh   = int'(c[1:0]) * 2;
          slot = 2'(rq.tb >> sh);
          case (slot)
            SLOT_PGM, SLOT_PGM_ALT: set_all_states(LED_PROGRAM);
            SLOT_PVW:               set_all_states(LED_PREVIEW);
            default:                set_all_states(LED_OFF);
          endcase
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_row(input logic [REQ_W-1:0] req, input int idx, input int st,
                                  input int r, input int g, input int b, input int bv,
                                  input int tb, input int ti, input check_kind_t chk,
                                  input int fg = 0, input int fr = 0, input int fb = 0);
    dir_row_t row;
    row.rq.req = req;
    row.rq.idx = LED_IDX_W'(idx);
    row.rq.st  = STATE_W'(st);
    row.rq.r   = 8'(r);
    row.rq.g   = 8'(g);
    row.rq.b   = 8'(b);
    row.rq.bv  = 8'(bv);
    row.rq.tb  = 8'(tb);
    row.rq.ti  = TALLY_IDX_W'(ti);
    row.chk    = chk;
    row.fg     = 8'(fg);
    row.fr     = 8'(fr);
    row.fb     = 8'(fb);
    directed.push_back(row);
  endfunction

  function automatic led_req_t random_request();
    led_req_t rq;
    int       pick;
    rq.idx = LED_IDX_W'($urandom_range(0, 7));
    rq.st  = STATE_W'($urandom_range(0, 7));
    rq.r   = 8'($urandom_range(0, 255));
    rq.g   = 8'($urandom_range(0, 255));
    rq.b   = 8'($urandom_range(0, 255));
    rq.bv  = 8'($urandom_range(0, 255));
    rq.tb  = 8'($urandom_range(0, 255));
    rq.ti  = TALLY_IDX_W'($urandom_range(0, 63));
    pick   = $urandom_range(0, 99);
    if (pick < 12)      rq.req = REQ_ALL_STATE;
    else if (pick < 24) rq.req = REQ_ALL_RGB;
    else if (pick < 38) rq.req = REQ_ONE_STATE;
    else if (pick < 52) rq.req = REQ_ONE_RGB;
    else if (pick < 66) rq.req = REQ_BRIGHT;
    else if (pick < 94) rq.req = REQ_TALLY;
    else                rq.req = pick[0] ? REQ_SPARE6 : REQ_SPARE7;
    if (rq.req == REQ_BRIGHT) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      rq.bv = bright;
      else if (pick == 1) rq.bv = 8'd0;
    end
    // mostly aim tally bytes at this camera's position in the packet
    if (rq.req == REQ_TALLY && $urandom_range(0, 3) != 0)
      rq.ti = TALLY_IDX_W'((cam - 8'd1) >> 2);
    return rq;
  endfunction

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input dir_row_t row);
    led_byte_t lb;
    in_req_type         <= row.rq.req;
    in_lamp_sel         <= row.rq.idx;
    in_lamp_code        <= row.rq.st;
    in_red              <= row.rq.r;
    in_green            <= row.rq.g;
    in_blue             <= row.rq.b;
    in_brightness_value <= row.rq.bv;
    in_tally_byte       <= row.rq.tb;
    in_tally_byte_index <= row.rq.ti;
    in_push             <= 1'b1;
    do @(posedge clk); while (in_full);
    apply_request(row.rq);
    case (row.chk)
      BY_MODEL: foreach (frame_scratch[i]) frame_bytes_due.push_back(frame_scratch[i]);
      FLAT_FRAME: begin
        for (int p = 0; p < FRAME_LEN; p++) begin
          lb.data = (p % 3 == 0) ? row.fg : (p % 3 == 1) ? row.fr : row.fb;
          lb.pos  = BYTE_IDX_W'(p);
          lb.last = (p == FRAME_LEN - 1);
          frame_bytes_due.push_back(lb);
        end
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic paced_send(input dir_row_t row);
    int gap;
    gap = (push_steady || $urandom_range(0, 9) < 6) ? 0 : idle_len();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    send_request(row);
  endtask

  task automatic wait_drained();
    while (frame_bytes_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_camera(input logic [7:0] v);
    wait_drained();
    // ignored requests may still sit in the command queue
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_camera_number <= v;
    cfg_valid         <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cam         = (v == 8'd0) ? 8'd1 : v;
    push_steady = ($urandom_range(0, 3) == 0);
    pop_steady  = ($urandom_range(0, 3) == 0);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int frames);
    dir_row_t row;
    int       acted;
    acted   = 0;
    row.chk = BY_MODEL;
    row.fg  = 8'd0;
    row.fr  = 8'd0;
    row.fb  = 8'd0;
    while (acted < frames) begin
      row.rq = random_request();
      paced_send(row);
      if (frame_scratch.size() != 0) acted++;
    end
    in_push <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      out_pop  <= 1'b0;
    end else if (pop_steady || $urandom_range(0, 3) != 0) begin
      out_pop <= 1'b1;
    end else begin
      out_pop  <= 1'b0;
      pop_hold <= idle_len() - 1;
    end
  end

  always @(posedge clk) begin : frame_monitor
    led_byte_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (frame_bytes_due.size() == 0) begin
        $display("%0t: frame byte %0d at index %0d with none expected",
                 $time, out_frame_byte, out_frame_byte_index);
        errors++;
      end else begin
        want = frame_bytes_due.pop_front();
        if (out_frame_byte !== want.data) begin
          $display("%0t: frame_byte expected %0d got %0d (index %0d)",
                   $time, want.data, out_frame_byte, want.pos);
          errors++;
        end
        if (out_frame_byte_index !== want.pos) begin
          $display("%0t: frame_byte_index expected %0d got %0d",
                   $time, want.pos, out_frame_byte_index);
          errors++;
        end
        if (out_frame_last !== want.last) begin
          $display("%0t: frame_last expected %0d got %0d (index %0d)",
                   $time, want.last, out_frame_last, want.pos);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [7:0] cam_plan [7];
    rst_n               = 1'b0;
    in_push             = 1'b0;
    in_req_type         = REQ_ALL_STATE;
    in_lamp_sel         = '0;
    in_lamp_code        = LED_OFF;
    in_red              = '0;
    in_green            = '0;
    in_blue             = '0;
    in_brightness_value = '0;
    in_tally_byte       = '0;
    in_tally_byte_index = '0;
    cfg_valid           = 1'b0;
    cfg_camera_number   = '0;

    // fields: req, idx, st, r, g, b, bv, tb, ti, check, then G R B of a uniform frame
    add_row(REQ_ALL_STATE, 0, LED_OFF,      0, 0, 0, 0, 0, 0, FLAT_FRAME,   0,   0,   0);
    add_row(REQ_ALL_STATE, 0, LED_PROGRAM,  0, 0, 0, 0, 0, 0, FLAT_FRAME,   0, 255,   0);
    add_row(REQ_ALL_STATE, 0, LED_PREVIEW,  0, 0, 0, 0, 0, 0, FLAT_FRAME, 255,   0,   0);
    add_row(REQ_ALL_STATE, 0, LED_LIVE,     0, 0, 0, 0, 0, 0, FLAT_FRAME,   0,   0, 255);
    add_row(REQ_ALL_STATE, 0, LED_BATT_LOW, 0, 0, 0, 0, 0, 0, FLAT_FRAME, 255, 255,   0);
    add_row(REQ_ALL_STATE, 0, LED_SPARE7,   0, 0, 0, 0, 0, 0, FLAT_FRAME,   0,   0,   0);
    add_row(REQ_ALL_RGB, 0, 0, 255, 255, 255, 0, 0, 0, FLAT_FRAME, 255, 255, 255);
    add_row(REQ_ALL_RGB, 7, 7,   0,   0,   0, 0, 0, 0, FLAT_FRAME,   0,   0,   0);
    add_row(REQ_ONE_STATE, 0, LED_PROGRAM, 0, 0, 0, 0, 0, 0, BY_MODEL);
    add_row(REQ_ONE_STATE, 7, LED_LIVE,    0, 0, 0, 0, 0, 0, BY_MODEL);
    add_row(REQ_ONE_RGB, 7, 0, 18, 52, 86, 0, 0, 0, BY_MODEL);
    add_row(REQ_ONE_RGB, 0, 0, 255, 0, 128, 0, 0, 0, BY_MODEL);
    // unchanged brightness, then zero taken as one, then one again
    add_row(REQ_BRIGHT, 0, 0, 0, 0, 0, 255, 0, 0, NO_FRAME);
    add_row(REQ_BRIGHT, 0, 0, 0, 0, 0,   0, 0, 0, BY_MODEL);
    add_row(REQ_BRIGHT, 0, 0, 0, 0, 0,   1, 0, 0, NO_FRAME);
    add_row(REQ_ALL_RGB, 0, 0, 255, 128, 1, 0, 0, 0, BY_MODEL);
    add_row(REQ_BRIGHT, 0, 0, 0, 0, 0, 128, 0, 0, BY_MODEL);
    add_row(REQ_BRIGHT, 0, 0, 0, 0, 0, 255, 0, 0, BY_MODEL);
    // camera 1 reads bits 1:0 of tally byte 0
    add_row(REQ_TALLY, 0, 0, 0, 0, 0, 0, 8'h01,  0, FLAT_FRAME,   0, 255, 0);
    add_row(REQ_TALLY, 0, 0, 0, 0, 0, 0, 8'h02,  0, FLAT_FRAME, 255,   0, 0);
    add_row(REQ_TALLY, 0, 0, 0, 0, 0, 0, 8'h03,  0, FLAT_FRAME,   0, 255, 0);
    add_row(REQ_TALLY, 0, 0, 0, 0, 0, 0, 8'hFC,  0, FLAT_FRAME,   0,   0, 0);
    add_row(REQ_TALLY, 0, 0, 0, 0, 0, 0, 8'hFF, 63, NO_FRAME);
    add_row(REQ_SPARE6, 7, 7, 255, 255, 255, 255, 255, 63, NO_FRAME);
    add_row(REQ_SPARE7, 0, 0,   0,   0,   0,   0,   0,  0, NO_FRAME);

    cam_plan[0] = 8'd255;
    cam_plan[1] = 8'd0;
    cam_plan[2] = 8'd4;
    cam_plan[3] = 8'd5;
    cam_plan[4] = 8'd128;
    cam_plan[5] = 8'($urandom_range(1, 255));
    cam_plan[6] = 8'($urandom_range(0, 255));

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < NLEDS; i++) led_st[i] = LED_OFF;
    bright = BRIGHT_RESET;
    cam    = CAM_RESET;

    foreach (directed[i]) paced_send(directed[i]);
    in_push <= 1'b0;

    foreach (cam_plan[i]) begin
      write_camera(cam_plan[i]);
      run_phase(PHASE_FRAMES);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && frame_bytes_due.size() == 0)
      $display("tally_led_frame_builder regression: pass");
    else
      $display("tally_led_frame_builder regression: fail");
    $finish;
  end

endmodule
